>>> hdl/cpdq_pkg.sv
// shared widths, coefficients, codes and sine table builder for the dq0 transform
package cpdq_pkg;

    localparam int S_W        = 16;
    localparam int ANG_W      = 16;
    localparam int SINE_DEPTH = 1024;
    localparam int IDX_W      = $clog2(SINE_DEPTH + 1);
    localparam int QS         = ANG_W - 2;
    localparam int KP_W       = QS + IDX_W;

    localparam int ROM_W  = 21;
    localparam int TRIG_W = ROM_W + 1;
    localparam int CF_W   = 22;
    localparam int U_W    = S_W + 3;
    localparam int P1_W   = CF_W + U_W + 1;
    localparam int X_W    = 28;
    localparam int Z_W    = S_W + 8;
    localparam int P2_W   = TRIG_W + X_W;
    localparam int SUM_W  = P2_W + 2;

    localparam int SH_XY  = 12;
    localparam int SH_Z   = 20;
    localparam int SH_OUT = 28;
    localparam int R_W    = SUM_W - SH_OUT;

    localparam logic FUNC_FWD = 1'b0;
    localparam logic FUNC_INV = 1'b1;
    localparam logic MODE_AMP = 1'b0;
    localparam logic MODE_PWR = 1'b1;

    localparam logic [ANG_W-1:0] QUARTER = ANG_W'(1) << QS;

    // q20 coefficients
    localparam logic signed [CF_W-1:0] K_THIRD      = CF_W'(349525);
    localparam logic signed [CF_W-1:0] K_INV_SQRT3  = CF_W'(605396);
    localparam logic signed [CF_W-1:0] K_INV_SQRT6  = CF_W'(428079);
    localparam logic signed [CF_W-1:0] K_INV_SQRT2  = CF_W'(741455);
    localparam logic signed [CF_W-1:0] K_SQRT3_HALF = CF_W'(908093);
    localparam logic signed [CF_W-1:0] K_SQRT2_3    = CF_W'(856159);
    localparam logic signed [CF_W-1:0] K_HALF       = CF_W'(524288);
    localparam logic signed [CF_W-1:0] K_ONE        = CF_W'(1048576);

    localparam logic signed [R_W-1:0] OUT_MAX = R_W'((1 << (S_W - 1)) - 1);
    localparam logic signed [R_W-1:0] OUT_MIN = R_W'(-(1 << (S_W - 1)));

    localparam longint unsigned ONE_Q20     = 64'd1048576;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int HORNER_N = 6;
    localparam longint unsigned HORNER_DIV [HORNER_N] = '{156, 110, 72, 42, 20, 6};

    typedef logic [ROM_W-1:0] t_sine_rom [SINE_DEPTH+1];

    // quarter-wave sine, q20, from a horner-form taylor series in q30
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            x  = HALF_PI_Q30 * longint'(k) / SINE_DEPTH;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            for (int i = 0; i < HORNER_N; i++) begin
                t = ONE_Q30 - ((x2 * t) >> 30) / HORNER_DIV[i];
            end
            s = (((x * t) >> 30) + 64'd512) >> 10;
            if (s > ONE_Q20) begin
                s = ONE_Q20;
            end
            rom[k] = ROM_W'(s);
        end
        return rom;
    endfunction

endpackage

>>> hdl/cpdq_in_if.sv
// input channel: phase or dq0 samples, angle and direction
interface cpdq_in_if import cpdq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic signed [S_W-1:0]   in_first;
    logic signed [S_W-1:0]   in_second;
    logic signed [S_W-1:0]   in_third;
    logic        [ANG_W-1:0] angle;

    modport source (
        output valid, func, in_first, in_second, in_third, angle,
        input  ready
    );
    modport sink (
        input  valid, func, in_first, in_second, in_third, angle,
        output ready
    );
endinterface

>>> hdl/cpdq_out_if.sv
// output channel: transformed samples and saturation flag
interface cpdq_out_if import cpdq_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic signed [S_W-1:0] out_first;
    logic signed [S_W-1:0] out_second;
    logic signed [S_W-1:0] out_third;
    logic                  saturated;

    modport source (
        output valid, out_first, out_second, out_third, saturated,
        input  ready
    );
    modport sink (
        input  valid, out_first, out_second, out_third, saturated,
        output ready
    );
endinterface

>>> hdl/clarke_park_dqz_transform_unit.sv
// clarke/park dq0 transform and its inverse, six-stage pipeline
//
// usage:
//   i_in is a valid/ready sink; a beat carries func (0 abc to dq0, 1 dq0 to abc),
//   three signed q2.14 samples and a 16-bit full-turn angle.
//   o_out is a valid/ready source with three saturated q2.14 results and a flag
//   that is set when any of them was clipped.
//   i_cfg_we/i_cfg_wdata write the scaling mode: 0 amplitude-invariant,
//   1 power-invariant; write it only while no beat is in flight.
// timing:
//   one beat per cycle enters and leaves when o_out.ready stays high.
//   stages: sine table read and sums, products, first rounding, rotation or
//   inverse clarke products, final sums and rounding, clipping into the
//   output register.
// stall:
//   each stage holds while the next one is full and stalled, empty stages
//   still fill, so i_in.ready drops only once the whole pipe is full.
// reset:
//   all stages empty and the mode returns to amplitude-invariant.
module clarke_park_dqz_transform_unit import cpdq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    cpdq_in_if.sink    i_in,
    cpdq_out_if.source o_out
);

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    localparam logic signed [P1_W:0]    HALF_XY  = (P1_W + 1)'(1) <<< (SH_XY - 1);
    localparam logic signed [P1_W-1:0]  HALF_Z   = P1_W'(1) <<< (SH_Z - 1);
    localparam logic signed [SUM_W-1:0] HALF_OUT = SUM_W'(1) <<< (SH_OUT - 1);

    function automatic logic [S_W:0] clip(input logic signed [R_W-1:0] v);
        logic [S_W:0] res;
        if (v > OUT_MAX) begin
            res = {1'b1, OUT_MAX[S_W-1:0]};
        end else if (v < OUT_MIN) begin
            res = {1'b1, OUT_MIN[S_W-1:0]};
        end else begin
            res = {1'b0, v[S_W-1:0]};
        end
        return res;
    endfunction

    logic r_mode;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic en1, en2, en3, en4, en5, en6;

    // stage 1
    logic [ANG_W-1:0]        cos_ang;
    logic [1:0]              sin_quad, cos_quad;
    logic [IDX_W-1:0]        sin_k, cos_k, sin_idx, cos_idx;
    logic                    r1_func, r1_mode;
    logic signed [S_W-1:0]   r1_p0, r1_p1, r1_p2;
    logic signed [U_W-1:0]   r1_u, r1_v, r1_w;
    logic [ROM_W-1:0]        r1_sin_mag, r1_cos_mag;
    logic                    r1_sin_neg, r1_cos_neg;

    // stage 2
    logic signed [TRIG_W-1:0] sn2, cs2;
    logic signed [CF_W-1:0]   kx, ky, kz;
    logic signed [P1_W-1:0]   n2_pa, n2_pb, n2_pc, n2_pd;
    logic                     r2_func, r2_mode;
    logic signed [S_W-1:0]    r2_p2;
    logic signed [TRIG_W-1:0] r2_sn, r2_cs;
    logic signed [P1_W-1:0]   r2_pa, r2_pb, r2_pc, r2_pd;

    // stage 3
    logic signed [P1_W:0]     n3_s1, n3_s2;
    logic signed [P1_W-1:0]   n3_zr;
    logic                     r3_func, r3_mode;
    logic signed [S_W-1:0]    r3_p2;
    logic signed [TRIG_W-1:0] r3_sn, r3_cs;
    logic signed [X_W-1:0]    r3_x, r3_y;
    logic signed [R_W-1:0]    r3_zero;

    // stage 4
    logic signed [CF_W-1:0]   ca, cb, cy, cz;
    logic signed [Z_W-1:0]    z4;
    logic signed [P2_W-1:0]   n4_a, n4_b, n4_c, n4_d;
    logic                     r4_func;
    logic signed [R_W-1:0]    r4_zero;
    logic signed [P2_W-1:0]   r4_a, r4_b, r4_c, r4_d;

    // stage 5
    logic signed [SUM_W-1:0]  a5, b5, c5, d5, s0, s1, s2;
    logic signed [SUM_W-1:0]  t0, t1, t2;
    logic signed [R_W-1:0]    n5_r0, n5_r1, n5_r2;
    logic signed [R_W-1:0]    r5_r0, r5_r1, r5_r2;

    // stage 6
    logic [S_W:0]             c0, c1, c2;
    logic signed [S_W-1:0]    r6_first, r6_second, r6_third;
    logic                     r6_sat;

    assign en6 = !r_v6 || o_out.ready;
    assign en5 = !r_v5 || en6;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_in.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_AMP;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_v6   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (en1) r_v1 <= i_in.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    // stage 1: table addresses and input sums
    assign cos_ang  = i_in.angle + QUARTER;
    assign sin_quad = i_in.angle[ANG_W-1 -: 2];
    assign cos_quad = cos_ang[ANG_W-1 -: 2];
    assign sin_k    = IDX_W'((KP_W'(i_in.angle[QS-1:0]) * KP_W'(SINE_DEPTH)) >> QS);
    assign cos_k    = IDX_W'((KP_W'(cos_ang[QS-1:0]) * KP_W'(SINE_DEPTH)) >> QS);
    assign sin_idx  = sin_quad[0] ? IDX_W'(SINE_DEPTH) - sin_k : sin_k;
    assign cos_idx  = cos_quad[0] ? IDX_W'(SINE_DEPTH) - cos_k : cos_k;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_func    <= i_in.func;
            r1_mode    <= r_mode;
            r1_p0      <= i_in.in_first;
            r1_p1      <= i_in.in_second;
            r1_p2      <= i_in.in_third;
            r1_u       <= (U_W'(i_in.in_first) <<< 1) - U_W'(i_in.in_second)
                          - U_W'(i_in.in_third);
            r1_v       <= U_W'(i_in.in_second) - U_W'(i_in.in_third);
            r1_w       <= U_W'(i_in.in_first) + U_W'(i_in.in_second) + U_W'(i_in.in_third);
            r1_sin_mag <= SINE_ROM[sin_idx];
            r1_cos_mag <= SINE_ROM[cos_idx];
            r1_sin_neg <= sin_quad[1];
            r1_cos_neg <= cos_quad[1];
        end
    end

    // stage 2: clarke products or first rotation products
    always_comb begin
        sn2 = r1_sin_neg ? -$signed({1'b0, r1_sin_mag}) : $signed({1'b0, r1_sin_mag});
        cs2 = r1_cos_neg ? -$signed({1'b0, r1_cos_mag}) : $signed({1'b0, r1_cos_mag});
        kx  = (r1_mode == MODE_PWR) ? K_INV_SQRT6 : K_THIRD;
        ky  = (r1_mode == MODE_PWR) ? K_INV_SQRT2 : K_INV_SQRT3;
        kz  = (r1_mode == MODE_PWR) ? K_INV_SQRT3 : K_THIRD;
        if (r1_func == FUNC_FWD) begin
            n2_pa = P1_W'(kx) * P1_W'(r1_u);
            n2_pb = P1_W'(ky) * P1_W'(r1_v);
            n2_pc = P1_W'(kz) * P1_W'(r1_w);
            n2_pd = '0;
        end else begin
            n2_pa = P1_W'(cs2) * P1_W'(r1_p0);
            n2_pb = P1_W'(sn2) * P1_W'(r1_p1);
            n2_pc = P1_W'(sn2) * P1_W'(r1_p0);
            n2_pd = P1_W'(cs2) * P1_W'(r1_p1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_func <= r1_func;
            r2_mode <= r1_mode;
            r2_p2   <= r1_p2;
            r2_sn   <= sn2;
            r2_cs   <= cs2;
            r2_pa   <= n2_pa;
            r2_pb   <= n2_pb;
            r2_pc   <= n2_pc;
            r2_pd   <= n2_pd;
        end
    end

    // stage 3: alpha/beta rounding, forward zero component
    always_comb begin
        if (r2_func == FUNC_FWD) begin
            n3_s1 = (P1_W + 1)'(r2_pa);
            n3_s2 = (P1_W + 1)'(r2_pb);
        end else begin
            n3_s1 = (P1_W + 1)'(r2_pa) - (P1_W + 1)'(r2_pb);
            n3_s2 = (P1_W + 1)'(r2_pc) + (P1_W + 1)'(r2_pd);
        end
        n3_zr = (r2_pc + HALF_Z) >>> SH_Z;
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_func <= r2_func;
            r3_mode <= r2_mode;
            r3_p2   <= r2_p2;
            r3_sn   <= r2_sn;
            r3_cs   <= r2_cs;
            r3_x    <= X_W'((n3_s1 + HALF_XY) >>> SH_XY);
            r3_y    <= X_W'((n3_s2 + HALF_XY) >>> SH_XY);
            r3_zero <= R_W'(n3_zr);
        end
    end

    // stage 4: park rotation or inverse clarke products
    always_comb begin
        ca = (r3_mode == MODE_PWR) ? K_SQRT2_3   : K_ONE;
        cb = (r3_mode == MODE_PWR) ? K_INV_SQRT6 : K_HALF;
        cy = (r3_mode == MODE_PWR) ? K_INV_SQRT2 : K_SQRT3_HALF;
        cz = (r3_mode == MODE_PWR) ? K_INV_SQRT3 : K_ONE;
        z4 = Z_W'(r3_p2) <<< 8;
        if (r3_func == FUNC_FWD) begin
            n4_a = P2_W'(r3_cs) * P2_W'(r3_x);
            n4_b = P2_W'(r3_sn) * P2_W'(r3_y);
            n4_c = P2_W'(r3_cs) * P2_W'(r3_y);
            n4_d = P2_W'(r3_sn) * P2_W'(r3_x);
        end else begin
            n4_a = P2_W'(ca) * P2_W'(r3_x);
            n4_b = P2_W'(cb) * P2_W'(r3_x);
            n4_c = P2_W'(cy) * P2_W'(r3_y);
            n4_d = P2_W'(cz) * P2_W'(z4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_func <= r3_func;
            r4_zero <= r3_zero;
            r4_a    <= n4_a;
            r4_b    <= n4_b;
            r4_c    <= n4_c;
            r4_d    <= n4_d;
        end
    end

    // stage 5: final sums and rounding
    always_comb begin
        a5 = SUM_W'(r4_a);
        b5 = SUM_W'(r4_b);
        c5 = SUM_W'(r4_c);
        d5 = SUM_W'(r4_d);
        if (r4_func == FUNC_FWD) begin
            s0 = a5 + b5;
            s1 = c5 - d5;
            s2 = '0;
        end else begin
            s0 = a5 + d5;
            s1 = c5 + d5 - b5;
            s2 = d5 - b5 - c5;
        end
        t0 = (s0 + HALF_OUT) >>> SH_OUT;
        t1 = (s1 + HALF_OUT) >>> SH_OUT;
        t2 = (s2 + HALF_OUT) >>> SH_OUT;
        n5_r0 = R_W'(t0);
        n5_r1 = R_W'(t1);
        n5_r2 = (r4_func == FUNC_FWD) ? r4_zero : R_W'(t2);
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_r0 <= n5_r0;
            r5_r1 <= n5_r1;
            r5_r2 <= n5_r2;
        end
    end

    // stage 6: clipping into the output register
    assign c0 = clip(r5_r0);
    assign c1 = clip(r5_r1);
    assign c2 = clip(r5_r2);

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r6_first  <= c0[S_W-1:0];
            r6_second <= c1[S_W-1:0];
            r6_third  <= c2[S_W-1:0];
            r6_sat    <= c0[S_W] | c1[S_W] | c2[S_W];
        end
    end

    assign o_out.valid      = r_v6;
    assign o_out.out_first  = r6_first;
    assign o_out.out_second = r6_second;
    assign o_out.out_third  = r6_third;
    assign o_out.saturated  = r6_sat;

endmodule

>>> test/clarke_park_dqz_transform_unit_test.sv
// self-checking testbench for the clarke/park dq0 transform unit with its own predictor
`timescale 1ns / 100ps

module clarke_park_dqz_transform_unit_test import cpdq_pkg::*; ();

    localparam int RUN_LIMIT = 200000;
    localparam int PHASE_BEATS = 338;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES = 80;

    localparam longint unsigned TAB_ONE_Q20 = 64'd1048576;
    localparam longint unsigned TAB_ONE_Q30 = 64'd1073741824;
    localparam longint unsigned TAB_HALF_PI = 64'd1686629713;

    localparam longint C_THIRD = 349525;
    localparam longint C_RSQRT3 = 605396;
    localparam longint C_RSQRT6 = 428079;
    localparam longint C_RSQRT2 = 741455;
    localparam longint C_SQRT3_HALF = 908093;
    localparam longint C_SQRT2_3 = 856159;
    localparam longint C_HALF = 524288;
    localparam longint C_ONE = 1048576;

    typedef struct packed {
        logic                    func;
        logic signed [S_W-1:0]   first;
        logic signed [S_W-1:0]   second;
        logic signed [S_W-1:0]   third;
        logic        [ANG_W-1:0] angle;
    } t_sample;

    typedef struct packed {
        logic signed [S_W-1:0] first;
        logic signed [S_W-1:0] second;
        logic signed [S_W-1:0] third;
        logic                  sat;
    } t_result;

    class dq0_checker;
        logic    mode;
        longint  quarter_sine [SINE_DEPTH+1];
        t_result due_results [$];
        int      mismatches;

        function new();
            longint unsigned x;
            longint unsigned x2;
            longint unsigned t;
            longint unsigned s;
            longint unsigned divs [6];
            divs = '{156, 110, 72, 42, 20, 6};
            mode = MODE_AMP;
            mismatches = 0;
            for (int k = 0; k <= SINE_DEPTH; k++) begin
                x = TAB_HALF_PI * longint'(k) / SINE_DEPTH;
                x2 = (x * x) >> 30;
                t = TAB_ONE_Q30;
                for (int i = 0; i < 6; i++) begin
                    t = TAB_ONE_Q30 - ((x2 * t) >> 30) / divs[i];
                end
                s = (((x * t) >> 30) + 64'd512) >> 10;
                if (s > TAB_ONE_Q20) begin
                    s = TAB_ONE_Q20;
                end
                quarter_sine[k] = longint'(s);
            end
        endfunction

        function longint sine_at(logic [ANG_W-1:0] ang);
            logic [1:0] quad;
            longint     k;
            longint     idx;
            longint     v;
            quad = ang[ANG_W-1 -: 2];
            k = (longint'(ang[QS-1:0]) * SINE_DEPTH) >>> QS;
            idx = quad[0] ? SINE_DEPTH - k : k;
            if (idx > SINE_DEPTH) begin
                idx = SINE_DEPTH;
            end
            v = quarter_sine[idx];
            return quad[1] ? -v : v;
        endfunction

        function longint round_shift(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function logic signed [S_W-1:0] clip(longint v, inout logic sat);
            if (v > 32767) begin
                sat = 1'b1;
                return 16'sh7fff;
            end
            if (v < -32768) begin
                sat = 1'b1;
                return 16'sh8000;
            end
            return S_W'(v);
        endfunction

        function t_result predict_transform(t_sample s);
            t_result r;
            logic    pwr;
            logic    sat;
            longint  p0, p1, p2, sn, cs, x, y, zt, r0, r1, r2;
            longint  kx, ky, kz, ca, cb, cy, cz;
            pwr = (mode == MODE_PWR);
            sat = 1'b0;
            p0 = longint'(s.first);
            p1 = longint'(s.second);
            p2 = longint'(s.third);
            sn = sine_at(s.angle);
            cs = sine_at(s.angle + QUARTER);
            if (s.func == FUNC_FWD) begin
                kx = pwr ? C_RSQRT6 : C_THIRD;
                ky = pwr ? C_RSQRT2 : C_RSQRT3;
                kz = pwr ? C_RSQRT3 : C_THIRD;
                x = round_shift(kx * (2 * p0 - p1 - p2), 12);
                y = round_shift(ky * (p1 - p2), 12);
                r2 = round_shift(kz * (p0 + p1 + p2), 20);
                r0 = round_shift(cs * x + sn * y, 28);
                r1 = round_shift(cs * y - sn * x, 28);
            end else begin
                ca = pwr ? C_SQRT2_3 : C_ONE;
                cb = pwr ? C_RSQRT6 : C_HALF;
                cy = pwr ? C_RSQRT2 : C_SQRT3_HALF;
                cz = pwr ? C_RSQRT3 : C_ONE;
                x = round_shift(cs * p0 - sn * p1, 12);
                y = round_shift(sn * p0 + cs * p1, 12);
                zt = cz * (p2 * 256);
                r0 = round_shift(ca * x + zt, 28);
                r1 = round_shift(-cb * x + cy * y + zt, 28);
                r2 = round_shift(-cb * x - cy * y + zt, 28);
            end
            r.first = clip(r0, sat);
            r.second = clip(r1, sat);
            r.third = clip(r2, sat);
            r.sat = sat;
            return r;
        endfunction

        function void note_sample(t_sample s);
            due_results.push_back(predict_transform(s));
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected beat: %0d %0d %0d sat %0b",
                             got.first, got.second, got.third, got.sat);
                end
                return;
            end
            want = due_results.pop_front();
            if (got.first !== want.first || got.second !== want.second ||
                got.third !== want.third || got.sat !== want.sat) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected %0d %0d %0d sat %0b, got %0d %0d %0d sat %0b",
                             want.first, want.second, want.third, want.sat,
                             got.first, got.second, got.third, got.sat);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_wdata;

    cpdq_in_if  in_bus ();
    cpdq_out_if out_bus ();

    dq0_checker checker_q = new();

    logic calm = 1'b0;
    int   cycles = 0;
    int   results_seen = 0;
    int   hold_left = 0;
    int   holds_done = 0;

    clarke_park_dqz_transform_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= RUN_LIMIT) begin
            $display("clarke_park_dqz_transform_unit_test NOT OK");
            $finish;
        end
    end

    // receiver: random stalls plus long hold-offs to back up the pipe
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
            checker_q.check_result('{out_bus.out_first, out_bus.out_second,
                                     out_bus.out_third, out_bus.saturated});
            results_seen++;
        end
        if (i_rst_n !== 1'b1) begin
            out_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_bus.ready <= 1'b0;
        end else if ((holds_done == 0 && results_seen >= 200) ||
                     (holds_done == 1 && results_seen >= 1000)) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= calm || ($urandom_range(99) >= 10);
        end
    end

    task automatic send_sample(input t_sample s);
        in_bus.valid <= 1'b1;
        in_bus.func <= s.func;
        in_bus.in_first <= s.first;
        in_bus.in_second <= s.second;
        in_bus.in_third <= s.third;
        in_bus.angle <= s.angle;
        do begin
            @(posedge i_clk);
        end while (in_bus.ready !== 1'b1);
        checker_q.note_sample(s);
        if (!calm && $urandom_range(99) < 10) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
    endtask

    task automatic send_fields(input logic f, input int a, input int b, input int c,
                               input int ang);
        send_sample('{f, S_W'(a), S_W'(b), S_W'(c), ANG_W'(ang)});
    endtask

    task automatic drain();
        in_bus.valid <= 1'b0;
        while (checker_q.due_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_mode(input logic m);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        checker_q.mode = m;
    endtask

    task automatic run_directed();
        send_fields(FUNC_FWD, 0, 0, 0, 0);
        send_fields(FUNC_FWD, 32767, 32767, 32767, 0);
        send_fields(FUNC_FWD, -32768, -32768, -32768, 16384);
        send_fields(FUNC_FWD, 32767, -32768, -32768, 0);
        send_fields(FUNC_FWD, -32768, 32767, 32767, 32768);
        send_fields(FUNC_FWD, 16384, -8192, -8192, 49152);
        send_fields(FUNC_FWD, 0, 32767, -32768, 65535);
        send_fields(FUNC_FWD, 12000, -3000, -9000, 8192);
        send_fields(FUNC_INV, 32767, 32767, 32767, 0);
        send_fields(FUNC_INV, -32768, -32768, -32768, 32768);
        send_fields(FUNC_INV, 16384, 0, 0, 16384);
        send_fields(FUNC_INV, 0, 16384, 0, 49151);
        send_fields(FUNC_INV, 0, 0, -32768, 24576);
    endtask

    function automatic logic signed [S_W-1:0] corner_value();
        case ($urandom_range(4))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return S_W'($urandom);
        endcase
    endfunction

    function automatic t_sample random_sample();
        t_sample s;
        s.func = 1'($urandom_range(1));
        case ($urandom_range(3))
            0, 1: begin
                s.first = S_W'($urandom);
                s.second = S_W'($urandom);
                s.third = S_W'($urandom);
            end
            2: begin
                s.first = S_W'(int'($urandom_range(16384)) - 8192);
                s.second = S_W'(int'($urandom_range(16384)) - 8192);
                s.third = S_W'(int'($urandom_range(16384)) - 8192);
            end
            default: begin
                s.first = corner_value();
                s.second = corner_value();
                s.third = corner_value();
            end
        endcase
        if ($urandom_range(7) == 0) begin
            s.angle = ANG_W'($urandom_range(3)) << QS;
            if ($urandom_range(1) == 1) begin
                s.angle = s.angle - 1'b1;
            end
        end else begin
            s.angle = ANG_W'($urandom);
        end
        return s;
    endfunction

    initial begin
        logic phase_modes [4];
        phase_modes = '{MODE_AMP, MODE_PWR, MODE_AMP, MODE_PWR};
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= 1'b0;
        in_bus.valid <= 1'b0;
        in_bus.func <= FUNC_FWD;
        in_bus.in_first <= '0;
        in_bus.in_second <= '0;
        in_bus.in_third <= '0;
        in_bus.angle <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain();
        write_mode(MODE_PWR);
        run_directed();
        drain();

        for (int p = 0; p < 4; p++) begin
            write_mode(phase_modes[p]);
            calm = (p == 1);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                send_sample(random_sample());
            end
            drain();
        end
        calm = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (checker_q.mismatches == 0 && checker_q.due_results.size() == 0) begin
            $display("clarke_park_dqz_transform_unit_test OK");
        end else begin
            $display("clarke_park_dqz_transform_unit_test NOT OK");
        end
        $finish;
    end

endmodule
